### hdl/lms_pkg.sv
// shared constants for the local maximum suppression block
// no dependencies; imported by the interfaces, the output queue and the top level
package lms_pkg;

    // default sizes
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int PIXEL_BITS_DEF = 16;

    // configuration register widths and port sizes
    localparam int WIDTH_BITS     = 11;
    localparam int HEIGHT_BITS    = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FRAME_HEIGHT = 1'd1;

    // reset values of the configuration registers
    localparam logic [WIDTH_BITS-1:0]  FRAME_WIDTH_RST  = 11'd4;
    localparam logic [HEIGHT_BITS-1:0] FRAME_HEIGHT_RST = 16'd4;

    // request kinds on the input channel
    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_FLUSH = 1'b1;

    // output queue depth
    localparam int FIFO_DEPTH = 4;

endpackage

### hdl/lms_if.sv
// valid/ready channel interfaces for pixel requests and results
// depends on lms_pkg
interface lms_in_if import lms_pkg::*; #(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         mode;
    logic signed [PIXEL_BITS-1:0] pixel_in;

    modport source (output valid, output mode, output pixel_in, input ready);
    modport sink   (input valid, input mode, input pixel_in, output ready);
endinterface

interface lms_out_if import lms_pkg::*; #(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [PIXEL_BITS-1:0] pixel_out;
    logic                         is_maximum;
    logic                         frame_end;

    modport source (output valid, output pixel_out, output is_maximum, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel_out, input is_maximum, input frame_end,
                    output ready);
endinterface

### hdl/lms_out_fifo.sv
// small result queue that decouples the compare stage from the output channel
// depends on lms_pkg and lms_out_if
module lms_out_fifo import lms_pkg::*; #(
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_push,
    input  logic signed [PIXEL_BITS-1:0]         i_pixel,
    input  logic                                 i_is_max,
    input  logic                                 i_frame_end,
    output logic [$clog2(FIFO_DEPTH+1)-1:0]      o_level,
    lms_out_if.source                            o_out
);
    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int LW = $clog2(FIFO_DEPTH+1);

    logic signed [PIXEL_BITS-1:0] r_pix [FIFO_DEPTH];
    logic                         r_max [FIFO_DEPTH];
    logic                         r_end [FIFO_DEPTH];
    logic [PW-1:0]                r_wr_ptr;
    logic [PW-1:0]                r_rd_ptr;
    logic [LW-1:0]                r_level;
    logic                         pop;

    // head of the queue drives the channel
    assign pop               = o_out.valid && o_out.ready;
    assign o_out.valid       = (r_level != '0);
    assign o_out.pixel_out   = r_pix[r_rd_ptr];
    assign o_out.is_maximum  = r_max[r_rd_ptr];
    assign o_out.frame_end   = r_end[r_rd_ptr];
    assign o_level           = r_level;

    // storage, space is reserved upstream so a push never meets a full queue
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_pix[r_wr_ptr] <= i_pixel;
            r_max[r_wr_ptr] <= i_is_max;
            r_end[r_wr_ptr] <= i_frame_end;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            if (i_push && !pop) begin
                r_level <= r_level + LW'(1);
            end else if (!i_push && pop) begin
                r_level <= r_level - LW'(1);
            end
        end
    end

endmodule

### hdl/local_maximum_suppression.sv
// channel  | dir | handshake            | payload
// i_in     | in  | valid / ready        | mode, pixel_in
// o_out    | out | valid / ready        | pixel_out, is_maximum, frame_end
// i_cfg_*  | in  | write enable only    | index, data (frame_width, frame_height)
//
// one request per clock while i_in.ready is high; the line stores are read in
// the cycle a request is accepted and written back in the cycle after, with
// forwarding across that gap. a result enters the output queue in the cycle
// after its request is accepted and can leave on the following clock.
// reset is synchronous; the line stores are not cleared and need no sweep.
// a four-entry result queue absorbs output stalls; i_in.ready drops only when
// the queue plus the result in flight could overflow it.
// depends on lms_pkg, lms_if and lms_out_fifo
module local_maximum_suppression import lms_pkg::*; #(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = PIXEL_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  i_cfg_data,
    lms_in_if.sink                    i_in,
    lms_out_if.source                 o_out
);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WB = $clog2(MAX_WIDTH+1);
    localparam int CW = (WB > WIDTH_BITS) ? WB : WIDTH_BITS;
    localparam int FW = $clog2(MAX_WIDTH+2);
    localparam int RB = HEIGHT_BITS + 1;
    localparam int LW = $clog2(FIFO_DEPTH+1);

    // configuration
    logic [WIDTH_BITS-1:0]  r_frame_width;
    logic [HEIGHT_BITS-1:0] r_frame_height;
    logic [WB-1:0]          w_use;
    logic [HEIGHT_BITS-1:0] h_use;

    // request-side control state
    logic [AW-1:0]          r_ring;
    logic [AW-1:0]          r_in_col;
    logic [HEIGHT_BITS-1:0] r_in_row;
    logic [AW-1:0]          r_out_col;
    logic [HEIGHT_BITS-1:0] r_out_row;
    logic                   r_frame_done;
    logic                   r_draining;
    logic [FW-1:0]          r_fill;

    // line stores and their read registers
    logic signed [PIXEL_BITS-1:0] r_mid_mem [MAX_WIDTH];
    logic signed [PIXEL_BITS-1:0] r_up_mem  [MAX_WIDTH];
    logic signed [PIXEL_BITS-1:0] r_mid_rd_a;
    logic signed [PIXEL_BITS-1:0] r_mid_rd_b;
    logic signed [PIXEL_BITS-1:0] r_up_rd;

    // compare stage
    logic                         r_s1_valid;
    logic                         r_s1_emit;
    logic signed [PIXEL_BITS-1:0] r_s1_v;
    logic [AW-1:0]                r_s1_addr;
    logic                         r_s1_col_first;
    logic                         r_s1_last_col;
    logic                         r_s1_row_first;
    logic                         r_s1_last_row;
    logic                         r_fwd_right;
    logic                         r_fwd_down;
    logic                         r_fwd_up;
    logic signed [PIXEL_BITS-1:0] r_fwd_mid_val;
    logic signed [PIXEL_BITS-1:0] r_fwd_up_val;
    logic signed [PIXEL_BITS-1:0] r_win_left;
    logic signed [PIXEL_BITS-1:0] r_win_centre;
    logic signed [PIXEL_BITS-1:0] r_win_upper;

    // combinational
    logic                         accept;
    logic                         is_pixel;
    logic                         flush_ok;
    logic                         adv;
    logic                         restart;
    logic                         emit;
    logic [FW-1:0]                fill_base;
    logic [AW-1:0]                oc_base;
    logic [HEIGHT_BITS-1:0]       or_base;
    logic [AW-1:0]                ring0;
    logic [AW-1:0]                prev0;
    logic [AW-1:0]                ring_next;
    logic                         in_last_col;
    logic                         in_last_row;
    logic                         out_last_col;
    logic                         out_last_row;
    logic [FW-1:0]                n_fill;
    logic                         n_draining;
    logic                         n_frame_done;
    logic [AW-1:0]                n_out_col;
    logic [HEIGHT_BITS-1:0]       n_out_row;
    logic signed [PIXEL_BITS-1:0] right_v;
    logic signed [PIXEL_BITS-1:0] down_v;
    logic signed [PIXEL_BITS-1:0] up_v;
    logic                         keep;
    logic                         s1_push;
    logic [LW-1:0]                fifo_level;

    // clamp the configured sizes
    always_comb begin
        if (r_frame_width == '0) begin
            w_use = WB'(1);
        end else if (CW'(r_frame_width) > CW'(MAX_WIDTH)) begin
            w_use = WB'(MAX_WIDTH);
        end else begin
            w_use = WB'(r_frame_width);
        end
        h_use = (r_frame_height == '0) ? HEIGHT_BITS'(1) : r_frame_height;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FRAME_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // room check: queue level plus the result in the compare stage
    assign s1_push    = r_s1_valid && r_s1_emit;
    assign i_in.ready = (fifo_level + LW'(s1_push)) <= LW'(FIFO_DEPTH - 1);
    assign accept     = i_in.valid && i_in.ready;

    // request decode
    assign is_pixel  = (i_in.mode == MODE_PIXEL);
    assign flush_ok  = r_frame_done && (r_fill != '0);
    assign adv       = is_pixel || flush_ok;
    assign restart   = is_pixel && r_draining;
    assign fill_base = restart ? '0 : r_fill;
    assign oc_base   = restart ? '0 : r_out_col;
    assign or_base   = restart ? '0 : r_out_row;
    assign emit      = is_pixel ? (fill_base >= FW'(w_use) + FW'(1)) : flush_ok;

    // line-store addresses
    always_comb begin
        ring0     = (WB'(r_ring) >= w_use) ? '0 : r_ring;
        prev0     = (ring0 == '0) ? AW'(w_use - WB'(1)) : ring0 - AW'(1);
        ring_next = (WB'(ring0) + WB'(1) >= w_use) ? '0 : ring0 + AW'(1);
    end

    // frame position tests
    assign in_last_col  = (WB'(r_in_col) + WB'(1) >= w_use);
    assign in_last_row  = (RB'(r_in_row) + RB'(1) >= RB'(h_use));
    assign out_last_col = (WB'(oc_base) + WB'(1) >= w_use);
    assign out_last_row = (RB'(or_base) + RB'(1) >= RB'(h_use));

    // next fill, drain and output position
    always_comb begin
        n_fill       = r_fill;
        n_draining   = r_draining;
        n_frame_done = r_frame_done;
        n_out_col    = oc_base;
        n_out_row    = or_base;
        if (is_pixel) begin
            n_fill       = emit ? fill_base : fill_base + FW'(1);
            n_draining   = 1'b0;
            n_frame_done = in_last_col && in_last_row;
        end else if (flush_ok) begin
            n_fill       = r_fill - FW'(1);
            n_draining   = (r_fill != FW'(1));
            n_frame_done = (r_fill != FW'(1));
        end
        if (emit) begin
            n_out_col = out_last_col ? '0 : oc_base + AW'(1);
            if (out_last_col) begin
                n_out_row = out_last_row ? '0 : or_base + HEIGHT_BITS'(1);
            end
        end
    end

    // request-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring       <= '0;
            r_in_col     <= '0;
            r_in_row     <= '0;
            r_out_col    <= '0;
            r_out_row    <= '0;
            r_frame_done <= 1'b0;
            r_draining   <= 1'b0;
            r_fill       <= '0;
        end else if (accept) begin
            r_fill       <= n_fill;
            r_draining   <= n_draining;
            r_frame_done <= n_frame_done;
            r_out_col    <= n_out_col;
            r_out_row    <= n_out_row;
            if (adv) begin
                r_ring <= ring_next;
            end
            if (is_pixel) begin
                r_in_col <= in_last_col ? '0 : r_in_col + AW'(1);
                if (in_last_col) begin
                    r_in_row <= in_last_row ? '0 : r_in_row + HEIGHT_BITS'(1);
                end
            end
        end
    end

    // line stores: read on accept, written back from the compare stage
    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_mid_mem[r_s1_addr] <= r_s1_v;
            r_up_mem[r_s1_addr]  <= right_v;
        end
        if (accept && adv) begin
            r_mid_rd_a <= r_mid_mem[ring0];
            r_mid_rd_b <= r_mid_mem[prev0];
            r_up_rd    <= r_up_mem[ring0];
        end
    end

    // stage register and forwarding from the write in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept && adv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && adv) begin
            r_s1_emit      <= emit;
            r_s1_v         <= is_pixel ? i_in.pixel_in : '0;
            r_s1_addr      <= ring0;
            r_s1_col_first <= (oc_base == '0);
            r_s1_last_col  <= out_last_col;
            r_s1_row_first <= (or_base == '0);
            r_s1_last_row  <= out_last_row;
            r_fwd_right    <= r_s1_valid && (r_s1_addr == ring0);
            r_fwd_down     <= r_s1_valid && (r_s1_addr == prev0);
            r_fwd_up       <= r_s1_valid && (r_s1_addr == ring0);
            r_fwd_mid_val  <= r_s1_v;
            r_fwd_up_val   <= right_v;
        end
    end

    // neighbor values after forwarding
    assign right_v = r_fwd_right ? r_fwd_mid_val : r_mid_rd_a;
    assign down_v  = r_fwd_down  ? r_fwd_mid_val : r_mid_rd_b;
    assign up_v    = r_fwd_up    ? r_fwd_up_val  : r_up_rd;

    // strict maximum test against the four neighbors
    assign keep = (r_s1_col_first || (r_win_centre > r_win_left))  &&
                  (r_s1_last_col  || (r_win_centre > right_v))     &&
                  (r_s1_row_first || (r_win_centre > r_win_upper)) &&
                  (r_s1_last_row  || (r_win_centre > down_v));

    // window shift
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_left   <= '0;
            r_win_centre <= '0;
            r_win_upper  <= '0;
        end else if (r_s1_valid) begin
            r_win_left   <= r_win_centre;
            r_win_centre <= right_v;
            r_win_upper  <= up_v;
        end
    end

    // result queue
    lms_out_fifo #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (s1_push),
        .i_pixel     (keep ? r_win_centre : '0),
        .i_is_max    (keep),
        .i_frame_end (r_s1_last_col && r_s1_last_row),
        .o_level     (fifo_level),
        .o_out       (o_out)
    );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// self-checking testbench for local_maximum_suppression: directed frame, then random frames
// depends on lms_pkg, lms_in_if / lms_out_if and the local_maximum_suppression top level
module tb_top;
    import lms_pkg::*;

    localparam int PB           = PIXEL_BITS_DEF;
    localparam int QUIET_CYCLES = 6;
    localparam int END_CYCLES   = 20;
    localparam int END_PIXELS   = 24;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 100;

    localparam logic signed [PB-1:0] PIX_MAX = 16'sh7FFF;
    localparam logic signed [PB-1:0] PIX_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [PB-1:0] pix;
        logic                 keep;
        logic                 last;
    } t_nms_result;

    // how a directed row gets its expectation
    typedef enum logic [1:0] {ROW_PREDICT, ROW_NONE, ROW_RESULT} t_row_kind;

    typedef struct packed {
        logic                 mode;
        logic signed [PB-1:0] pix;
        t_row_kind            kind;
        t_nms_result          want;
    } t_stim_row;

    localparam t_nms_result NO_HIT  = '{16'sh0000, 1'b0, 1'b0};
    localparam t_nms_result HIT_MAX = '{PIX_MAX, 1'b1, 1'b0};

    // 4x4 frame at the reset sizes; results lag by five requests
    localparam int NUM_ROWS = 21;
    localparam t_stim_row DIRECTED [NUM_ROWS] = '{
        '{MODE_FLUSH, 16'sh0000, ROW_NONE,    NO_HIT},   // flush with no frame
        '{MODE_PIXEL, PIX_MAX,   ROW_NONE,    NO_HIT},
        '{MODE_PIXEL, PIX_MIN,   ROW_NONE,    NO_HIT},
        '{MODE_PIXEL, PIX_MIN,   ROW_NONE,    NO_HIT},
        '{MODE_PIXEL, PIX_MAX,   ROW_NONE,    NO_HIT},
        '{MODE_PIXEL, PIX_MIN,   ROW_NONE,    NO_HIT},
        '{MODE_PIXEL, PIX_MAX,   ROW_RESULT,  HIT_MAX},  // top-left corner kept
        '{MODE_PIXEL, PIX_MIN,   ROW_RESULT,  NO_HIT},
        '{MODE_PIXEL, PIX_MIN,   ROW_RESULT,  NO_HIT},
        '{MODE_PIXEL, PIX_MIN,   ROW_RESULT,  HIT_MAX},  // top-right corner kept
        '{MODE_PIXEL, PIX_MIN,   ROW_RESULT,  NO_HIT},
        '{MODE_PIXEL, -16'sd1,   ROW_RESULT,  HIT_MAX},  // inner peak kept
        '{MODE_PIXEL, -16'sd1,   ROW_RESULT,  NO_HIT},
        '{MODE_PIXEL, PIX_MAX,   ROW_RESULT,  NO_HIT},
        '{MODE_PIXEL, PIX_MIN,   ROW_RESULT,  NO_HIT},
        '{MODE_PIXEL, PIX_MIN,   ROW_RESULT,  NO_HIT},
        '{MODE_PIXEL, PIX_MAX,   ROW_RESULT,  NO_HIT},   // equal pair at -1 both dropped
        '{MODE_FLUSH, 16'sh0000, ROW_RESULT,  NO_HIT},
        '{MODE_FLUSH, 16'shFFFF, ROW_RESULT,  HIT_MAX},  // bottom-left corner kept
        '{MODE_PIXEL, 16'sh5A5A, ROW_PREDICT, NO_HIT},   // pixel during drain
        '{MODE_FLUSH, 16'sh0000, ROW_PREDICT, NO_HIT}    // flush inside an open frame
    };

    // random phases: frame sizes written, random requests, idling off in one
    localparam int NUM_PHASES = 8;
    localparam int unsigned PH_WIDTH  [NUM_PHASES] = '{3, 1, 0, 7, 2, 1, 5, 1024};
    localparam int unsigned PH_HEIGHT [NUM_PHASES] = '{5, 1, 0, 2, 9, 6, 1, 1};
    localparam int unsigned PH_ITEMS  [NUM_PHASES] = '{60, 30, 15, 45, 50, 20, 30, 0};
    localparam int CALM_PHASE = 3;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data;

    lms_in_if  #(.PIXEL_BITS(PB)) in_ch ();
    lms_out_if #(.PIXEL_BITS(PB)) out_ch ();

    local_maximum_suppression #(
        .MAX_WIDTH  (MAX_WIDTH_DEF),
        .PIXEL_BITS (PB)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // expected suppression results, oldest first
    t_nms_result nms_due [$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          calm = 1'b0;

    // predictor state
    logic [WIDTH_BITS-1:0]  cfg_width;
    logic [HEIGHT_BITS-1:0] cfg_height;
    logic signed [PB-1:0]   upper_line  [MAX_WIDTH_DEF];
    logic signed [PB-1:0]   middle_line [MAX_WIDTH_DEF];
    logic signed [PB-1:0]   win_left, win_mid, win_up;
    int unsigned            in_col, in_row, out_col, out_row, fill, wr_pos;
    bit                     frame_done, draining;

    function automatic void clear_model();
        cfg_width  = FRAME_WIDTH_RST;
        cfg_height = FRAME_HEIGHT_RST;
        foreach (upper_line[k]) begin
            upper_line[k]  = '0;
            middle_line[k] = '0;
        end
        win_left = '0;
        win_mid  = '0;
        win_up   = '0;
        in_col = 0;
        in_row = 0;
        out_col = 0;
        out_row = 0;
        fill = 0;
        wr_pos = 0;
        frame_done = 1'b0;
        draining = 1'b0;
    endfunction

    function automatic int unsigned used_width();
        if (cfg_width == 0) return 1;
        if (cfg_width > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return 32'(cfg_width);
    endfunction

    function automatic int unsigned used_height();
        if (cfg_height == 0) return 1;
        return 32'(cfg_height);
    endfunction

    // shift one value through the line stores, judging the pixel under test if asked
    function automatic void push_column(input logic signed [PB-1:0] v, input bit judge,
                                        inout t_nms_result r);
        int unsigned          w, h, prev;
        logic signed [PB-1:0] right_px, down_px, old_up;
        bit                   last_col, last_row, keep;
        w = used_width();
        h = used_height();
        if (wr_pos >= w) wr_pos = 0;
        prev = (wr_pos + w - 1) % w;
        right_px = middle_line[wr_pos];
        down_px  = middle_line[prev];
        old_up   = upper_line[wr_pos];

        if (judge) begin
            last_col = out_col + 1 >= w;
            last_row = out_row + 1 >= h;
            keep = (out_col == 0 || win_mid > win_left) &&
                   (last_col     || win_mid > right_px) &&
                   (out_row == 0 || win_mid > win_up)   &&
                   (last_row     || win_mid > down_px);
            r.pix  = keep ? win_mid : '0;
            r.keep = keep;
            r.last = last_col && last_row;
            if (last_col) begin
                out_col = 0;
                out_row = last_row ? 0 : out_row + 1;
            end else begin
                out_col++;
            end
        end

        win_left = win_mid;
        win_mid  = right_px;
        win_up   = old_up;
        upper_line[wr_pos]  = right_px;
        middle_line[wr_pos] = v;
        wr_pos = (wr_pos + 1 >= w) ? 0 : wr_pos + 1;
    endfunction

    // one accepted request; returns 1 when it releases a result
    function automatic bit nms_step(input logic mode, input logic signed [PB-1:0] pix,
                                    output t_nms_result r);
        int unsigned w, h;
        bit          judge, last;
        w = used_width();
        h = used_height();
        r = '0;
        if (mode == MODE_PIXEL) begin
            // a pixel inside a drain drops the rest and opens a new frame
            if (draining) begin
                fill = 0;
                draining = 1'b0;
                frame_done = 1'b0;
                out_col = 0;
                out_row = 0;
            end
            judge = fill >= w + 1;
            if (!judge) fill++;
            push_column(pix, judge, r);
            last = (in_col + 1 >= w) && (in_row + 1 >= h);
            if (in_col + 1 >= w) begin
                in_col = 0;
                in_row = (in_row + 1 >= h) ? 0 : in_row + 1;
            end else begin
                in_col++;
            end
            frame_done = last;
            return judge;
        end
        // flush only drains a completed frame
        if (!frame_done || fill == 0) return 1'b0;
        draining = 1'b1;
        push_column('0, 1'b1, r);
        fill--;
        if (fill == 0) begin
            frame_done = 1'b0;
            draining = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic signed [PB-1:0] pick_pixel();
        logic signed [PB-1:0] v;
        case ($urandom_range(9))
            0: v = PIX_MAX;
            1: v = PIX_MIN;
            // narrow range so that plateaus and ties are common
            2, 3: begin
                v = PB'($urandom_range(4));
                v = v - 16'sd2;
            end
            default: v = PB'($urandom);
        endcase
        return v;
    endfunction

    // hold one request until accepted, sometimes after an idle gap
    task automatic put_request(input logic mode, input logic signed [PB-1:0] pix);
        if (!calm && $urandom_range(99) < 25) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.mode     <= mode;
        in_ch.pixel_in <= pix;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic issue(input logic mode, input logic signed [PB-1:0] pix);
        t_nms_result r;
        put_request(mode, pix);
        if (nms_step(mode, pix, r)) nms_due.push_back(r);
    endtask

    // random frames: mostly whole frames, with drains cut short, frames back to back
    // and stray flushes mixed in
    task automatic stream_frames(input int unsigned count);
        int unsigned sent, flushes;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 6) begin
                issue(MODE_FLUSH, PB'($urandom));
                sent++;
            end else begin
                issue(MODE_PIXEL, pick_pixel());
                sent++;
                if (frame_done) begin
                    case ($urandom_range(3))
                        0, 1: flushes = fill + $urandom_range(2);
                        2:    flushes = $urandom_range(fill, 1);
                        default: flushes = 0;
                    endcase
                    repeat (flushes) begin
                        issue(MODE_FLUSH, PB'($urandom));
                        sent++;
                    end
                end
            end
        end
    endtask

    // finish the open frame, drain it and let the block go quiet
    task automatic settle();
        while (fill != 0) issue(frame_done ? MODE_FLUSH : MODE_PIXEL, pick_pixel());
        in_ch.valid <= 1'b0;
        while (nms_due.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // both size registers in consecutive cycles
    task automatic set_frame(input int unsigned w, input int unsigned h);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_FRAME_WIDTH;
        i_cfg_data  <= CFG_DATA_BITS'(w);
        @(posedge i_clk);
        cfg_width = WIDTH_BITS'(w);
        i_cfg_index <= CFG_FRAME_HEIGHT;
        i_cfg_data  <= CFG_DATA_BITS'(h);
        @(posedge i_clk);
        cfg_height = HEIGHT_BITS'(h);
        i_cfg_we <= 1'b0;
    endtask

    // result side: random backpressure and comparison against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_nms_result want;
        out_ch.ready <= calm || ($urandom_range(99) >= 30);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (nms_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result pixel_out %0d is_maximum %0b frame_end %0b",
                             $time, out_ch.pixel_out, out_ch.is_maximum, out_ch.frame_end);
            end else begin
                want = nms_due.pop_front();
                if (out_ch.pixel_out !== want.pix || out_ch.is_maximum !== want.keep ||
                    out_ch.frame_end !== want.last) begin
                    mismatches++;
                    // keep the log short on a badly broken design
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: expected %0d/%0b/%0b got %0d/%0b/%0b", $time,
                                 want.pix, want.keep, want.last, out_ch.pixel_out,
                                 out_ch.is_maximum, out_ch.frame_end);
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_stim_row   row;
        t_nms_result got;
        bit          hit;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_FRAME_WIDTH;
        i_cfg_data     = '0;
        in_ch.valid    = 1'b0;
        in_ch.mode     = MODE_PIXEL;
        in_ch.pixel_in = '0;
        clear_model();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frame at the reset sizes
        for (int k = 0; k < NUM_ROWS; k++) begin
            row = DIRECTED[k];
            put_request(row.mode, row.pix);
            hit = nms_step(row.mode, row.pix, got);
            if (row.kind == ROW_RESULT) begin
                nms_due.push_back(row.want);
            end else if (row.kind == ROW_PREDICT && hit) begin
                nms_due.push_back(got);
            end
        end

        // random frames, first at the reset sizes, then at each written size
        stream_frames(40);
        settle();
        for (int p = 0; p < NUM_PHASES; p++) begin
            calm = (p == CALM_PHASE);
            set_frame(PH_WIDTH[p], PH_HEIGHT[p]);
            stream_frames(PH_ITEMS[p]);
            settle();
        end
        calm = 1'b0;

        // oversized width and tallest frame, left open at the end
        set_frame(2047, 65535);
        repeat (END_PIXELS) begin
            if ($urandom_range(99) < 5) issue(MODE_FLUSH, PB'($urandom));
            issue(MODE_PIXEL, pick_pixel());
        end
        in_ch.valid <= 1'b0;

        while (nms_due.size() != 0) @(posedge i_clk);
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && nms_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
